// ===== sv/ldcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helpers for the lens distortion coordinate map.
package ldcm_pkg;

    localparam int IMG_WIDTH_DEF       = 1280;
    localparam int IMG_HEIGHT_DEF      = 1024;
    localparam int CENTER_X_DEF        = 640;
    localparam int CENTER_Y_DEF        = 512;
    localparam int COEF_FRAC_BITS_DEF  = 24;
    localparam int COORD_FRAC_BITS_DEF = 28;
    localparam int QUEUE_DEPTH_DEF     = 4;

    localparam int ROW_W   = 10;
    localparam int COL_W   = 11;
    localparam int FOCAL_W = 13;
    localparam int COEF_W  = 32;
    localparam int WORD_W  = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FOCAL_X = 3'd0,
        REG_FOCAL_Y = 3'd1,
        REG_K1      = 3'd2,
        REG_K2      = 3'd3,
        REG_K3      = 3'd4,
        REG_P1      = 3'd5,
        REG_P2      = 3'd6
    } ldcm_reg_t;

    typedef struct packed {
        logic [FOCAL_W-1:0]       focal_x;
        logic [FOCAL_W-1:0]       focal_y;
        logic signed [COEF_W-1:0] k1;
        logic signed [COEF_W-1:0] k2;
        logic signed [COEF_W-1:0] k3;
        logic signed [COEF_W-1:0] p1;
        logic signed [COEF_W-1:0] p2;
    } ldcm_cfg_t;

    // normalized coordinate pair handed from front to back
    typedef struct packed {
        logic signed [WORD_W-1:0] x;
        logic signed [WORD_W-1:0] y;
    } ldcm_norm_t;

    typedef struct packed {
        logic push;
        logic full;
    } ldcm_qctl_t;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [WORD_W-1:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFFFFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[WORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/ldcm_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts coordinates and normalizes them with a pipelined restoring divider.
module ldcm_front #(
    parameter int CENTER_X        = ldcm_pkg::CENTER_X_DEF,
    parameter int CENTER_Y        = ldcm_pkg::CENTER_Y_DEF,
    parameter int COORD_FRAC_BITS = ldcm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ldcm_pkg::ROW_W-1:0]    dest_row,
    input  logic [ldcm_pkg::COL_W-1:0]    dest_col,
    input  logic [ldcm_pkg::FOCAL_W-1:0]  focal_x,
    input  logic [ldcm_pkg::FOCAL_W-1:0]  focal_y,
    output ldcm_pkg::ldcm_qctl_t          qctl_out,
    input  logic                          q_full,
    output ldcm_pkg::ldcm_norm_t          q_item
);
    import ldcm_pkg::*;

    localparam int F     = COORD_FRAC_BITS;
    localparam int MAG_W = 12;
    localparam int QW    = MAG_W + F;   // quotient bits, one per stage

    logic [FOCAL_W-1:0] remx_reg [QW];
    logic [FOCAL_W-1:0] remy_reg [QW];
    logic [QW-1:0]      numx_reg [QW];
    logic [QW-1:0]      numy_reg [QW];
    logic [FOCAL_W-1:0] remx_next [QW];
    logic [FOCAL_W-1:0] remy_next [QW];
    logic [QW-1:0]      numx_next [QW];
    logic [QW-1:0]      numy_next [QW];
    logic [QW-1:0]      vld_reg, negx_reg, negy_reg;

    logic [FOCAL_W-1:0] fx, fy;
    logic signed [12:0] dx, dy;
    logic [MAG_W-1:0]   magx, magy;
    logic               en;

    assign fx = (focal_x == '0) ? FOCAL_W'(1) : focal_x;
    assign fy = (focal_y == '0) ? FOCAL_W'(1) : focal_y;
    assign dx = signed'({2'b00, dest_col}) - 13'(CENTER_X);
    assign dy = signed'({3'b000, dest_row}) - 13'(CENTER_Y);
    assign magx = dx[12] ? MAG_W'(-dx) : dx[MAG_W-1:0];
    assign magy = dy[12] ? MAG_W'(-dy) : dy[MAG_W-1:0];

    // whole front holds only when a finished item cannot enter the queue
    assign en       = !(vld_reg[QW-1] && q_full);
    assign in_ready = en;

    always_comb begin
        logic [FOCAL_W-1:0] rxi, ryi;
        logic [QW-1:0]      nxi, nyi;
        logic [FOCAL_W:0]   tx, ty;
        logic               gx, gy;
        for (int s = 0; s < QW; s++) begin
            if (s == 0) begin
                rxi = '0;
                ryi = '0;
                nxi = {magx, {F{1'b0}}};
                nyi = {magy, {F{1'b0}}};
            end else begin
                rxi = remx_reg[s-1];
                ryi = remy_reg[s-1];
                nxi = numx_reg[s-1];
                nyi = numy_reg[s-1];
            end
            tx = {rxi, nxi[QW-1]};
            ty = {ryi, nyi[QW-1]};
            gx = (tx >= {1'b0, fx});
            gy = (ty >= {1'b0, fy});
            remx_next[s] = gx ? FOCAL_W'(tx - {1'b0, fx}) : tx[FOCAL_W-1:0];
            remy_next[s] = gy ? FOCAL_W'(ty - {1'b0, fy}) : ty[FOCAL_W-1:0];
            numx_next[s] = {nxi[QW-2:0], gx};
            numy_next[s] = {nyi[QW-2:0], gy};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            negx_reg <= {negx_reg[QW-2:0], dx[12]};
            negy_reg <= {negy_reg[QW-2:0], dy[12]};
            for (int s = 0; s < QW; s++) begin
                remx_reg[s] <= remx_next[s];
                remy_reg[s] <= remy_next[s];
                numx_reg[s] <= numx_next[s];
                numy_reg[s] <= numy_next[s];
            end
        end
    end

    always_comb begin
        logic signed [63:0] qx, qy;
        qx = signed'(64'(numx_reg[QW-1]));
        qy = signed'(64'(numy_reg[QW-1]));
        q_item.x = sat32(negx_reg[QW-1] ? -qx : qx);
        q_item.y = sat32(negy_reg[QW-1] ? -qy : qy);
    end

    assign qctl_out.push = vld_reg[QW-1] && !q_full;
    assign qctl_out.full = q_full;

endmodule

// ===== sv/ldcm_fifo.sv =====
`timescale 1ns / 1ps
// Short queue between the front and back ends.
module ldcm_fifo #(
    parameter int DEPTH = ldcm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ldcm_pkg::ldcm_qctl_t qctl_in,
    input  ldcm_pkg::ldcm_norm_t wr_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 empty,
    output ldcm_pkg::ldcm_norm_t rd_item
);
    import ldcm_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    ldcm_norm_t      mem [DEPTH];
    logic [AW-1:0]   wptr_reg, rptr_reg;
    logic [AW:0]     cnt_reg;
    logic            do_pop;

    assign full   = (cnt_reg == (AW+1)'(DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_pop = pop && !empty;
    assign rd_item = mem[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (qctl_in.push) begin
                wptr_reg <= (wptr_reg == AW'(DEPTH-1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == AW'(DEPTH-1)) ? '0 : rptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(qctl_in.push) - (AW+1)'(do_pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (qctl_in.push) begin
            mem[wptr_reg] <= wr_item;
        end
    end

endmodule

// ===== sv/ldcm_back.sv =====
`timescale 1ns / 1ps
// Back end: distortion polynomial, rescale to pixels, inside test and rounding.
module ldcm_back #(
    parameter int IMG_WIDTH       = ldcm_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT      = ldcm_pkg::IMG_HEIGHT_DEF,
    parameter int CENTER_X        = ldcm_pkg::CENTER_X_DEF,
    parameter int CENTER_Y        = ldcm_pkg::CENTER_Y_DEF,
    parameter int COEF_FRAC_BITS  = ldcm_pkg::COEF_FRAC_BITS_DEF,
    parameter int COORD_FRAC_BITS = ldcm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ldcm_pkg::ldcm_cfg_t        cfg,
    input  logic                       q_empty,
    input  ldcm_pkg::ldcm_norm_t       q_item,
    output logic                       q_pop,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ldcm_pkg::ROW_W-1:0] src_row,
    output logic [ldcm_pkg::COL_W-1:0] src_col,
    output logic                       inside_res
);
    import ldcm_pkg::*;

    localparam int F = COORD_FRAC_BITS;
    localparam int C = COEF_FRAC_BITS;
    localparam int NS = 10;
    localparam logic signed [63:0] ONE_FIX = 64'sd1 <<< F;
    localparam logic signed [47:0] CX_FIX  = 48'sd0 + (48'(CENTER_X) << F);
    localparam logic signed [47:0] CY_FIX  = 48'sd0 + (48'(CENTER_Y) << F);
    localparam logic signed [47:0] W_FIX   = 48'sd0 + (48'(IMG_WIDTH) << F);
    localparam logic signed [47:0] H_FIX   = 48'sd0 + (48'(IMG_HEIGHT) << F);
    localparam logic signed [47:0] HALF    = 48'sd1 <<< (F-1);

    logic [NS-1:0] vld_reg;
    logic          en;

    typedef logic signed [WORD_W-1:0] w_t;
    typedef logic signed [63:0]       d_t;

    w_t x1_reg, y1_reg, xx1_reg, yy1_reg, xy1_reg;
    w_t x2_reg, y2_reg, r2_2_reg, txy2_reg, a2_reg, b2_reg;
    w_t x3_reg, y3_reg, r2_3_reg, r4_3_reg;
    d_t k1t3_reg, tp1_3_reg, tp2_3_reg, tq1_3_reg, tq2_3_reg;
    w_t x4_reg, y4_reg, r6_4_reg, tx4_reg, ty4_reg;
    d_t sum4_reg;
    w_t x5_reg, y5_reg, tx5_reg, ty5_reg;
    d_t sum5_reg;
    w_t x6_reg, y6_reg, tx6_reg, ty6_reg, rad6_reg;
    w_t tx7_reg, ty7_reg;
    d_t xr7_reg, yr7_reg;
    w_t xd8_reg, yd8_reg;
    logic signed [47:0] px9_reg, py9_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_reg;
    logic             in_reg;

    assign en    = !vld_reg[NS-1] || out_ready;
    assign q_pop = en && !q_empty;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], !q_empty};
        end
    end

    always_ff @(posedge aclk) begin
        d_t p0, p1, p2, p3, p4, p5;
        logic signed [47:0] pos_x, pos_y, rx, ry;
        logic [12:0] cr, cc;
        logic ic, ir;
        if (en) begin
            // squares and cross term
            x1_reg  <= q_item.x;
            y1_reg  <= q_item.y;
            p0 = q_item.x * q_item.x;
            p1 = q_item.y * q_item.y;
            p2 = q_item.x * q_item.y;
            xx1_reg <= sat32(p0 >>> F);
            yy1_reg <= sat32(p1 >>> F);
            xy1_reg <= sat32(p2 >>> F);

            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            r2_2_reg <= sat32(64'(xx1_reg) + 64'(yy1_reg));
            txy2_reg <= sat32(64'(xy1_reg) <<< 1);
            a2_reg   <= sat32(64'(sat32(64'(xx1_reg) + 64'(yy1_reg))) + (64'(xx1_reg) <<< 1));
            b2_reg   <= sat32(64'(sat32(64'(xx1_reg) + 64'(yy1_reg))) + (64'(yy1_reg) <<< 1));

            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            r2_3_reg <= r2_2_reg;
            p0 = r2_2_reg * r2_2_reg;
            r4_3_reg <= sat32(p0 >>> F);
            p1 = cfg.k1 * r2_2_reg;
            k1t3_reg  <= p1 >>> C;
            p2 = cfg.p1 * txy2_reg;
            tp1_3_reg <= p2 >>> C;
            p3 = cfg.p2 * a2_reg;
            tp2_3_reg <= p3 >>> C;
            p4 = cfg.p1 * b2_reg;
            tq1_3_reg <= p4 >>> C;
            p5 = cfg.p2 * txy2_reg;
            tq2_3_reg <= p5 >>> C;

            x4_reg   <= x3_reg;
            y4_reg   <= y3_reg;
            p0 = r4_3_reg * r2_3_reg;
            r6_4_reg <= sat32(p0 >>> F);
            p1 = cfg.k2 * r4_3_reg;
            sum4_reg <= k1t3_reg + (p1 >>> C);
            tx4_reg  <= sat32(tp1_3_reg + tp2_3_reg);
            ty4_reg  <= sat32(tq1_3_reg + tq2_3_reg);

            x5_reg   <= x4_reg;
            y5_reg   <= y4_reg;
            tx5_reg  <= tx4_reg;
            ty5_reg  <= ty4_reg;
            p0 = cfg.k3 * r6_4_reg;
            sum5_reg <= sum4_reg + (p0 >>> C);

            x6_reg   <= x5_reg;
            y6_reg   <= y5_reg;
            tx6_reg  <= tx5_reg;
            ty6_reg  <= ty5_reg;
            rad6_reg <= sat32(ONE_FIX + sum5_reg);

            tx7_reg <= tx6_reg;
            ty7_reg <= ty6_reg;
            p0 = x6_reg * rad6_reg;
            p1 = y6_reg * rad6_reg;
            xr7_reg <= p0 >>> F;
            yr7_reg <= p1 >>> F;

            xd8_reg <= sat32(xr7_reg + 64'(tx7_reg));
            yd8_reg <= sat32(yr7_reg + 64'(ty7_reg));

            // back to pixels; focal used as written here, zero included
            px9_reg <= CX_FIX + xd8_reg * signed'({1'b0, cfg.focal_x});
            py9_reg <= CY_FIX + yd8_reg * signed'({1'b0, cfg.focal_y});

            pos_x = px9_reg;
            pos_y = py9_reg;
            ic = (pos_x >= 0) && (pos_x < W_FIX);
            ir = (pos_y >= 0) && (pos_y < H_FIX);
            rx = (pos_x + HALF) >>> F;
            ry = (pos_y + HALF) >>> F;
            cc = (rx[12:0] > 13'(IMG_WIDTH - 1))  ? 13'(IMG_WIDTH - 1)  : rx[12:0];
            cr = (ry[12:0] > 13'(IMG_HEIGHT - 1)) ? 13'(IMG_HEIGHT - 1) : ry[12:0];
            in_reg  <= ic && ir;
            col_reg <= (ic && ir) ? cc[COL_W-1:0] : '0;
            row_reg <= (ic && ir) ? cr[ROW_W-1:0] : '0;
        end
    end

    assign out_valid  = vld_reg[NS-1];
    assign src_row    = row_reg;
    assign src_col    = col_reg;
    assign inside_res = in_reg;

endmodule

// ===== sv/lens_distortion_coordinate_map.sv =====
`timescale 1ns / 1ps
// Top level of the lens distortion coordinate map.
//
// Input channel s_*: one destination pixel (row, column) per item.
// Output channel m_*: the source pixel to sample and an inside flag in m_tuser;
// when the flag is low the pixel is black and row and column are zero.
// Configuration: cfg_we / cfg_addr / cfg_wdata write focal lengths and the
// Q8.24 coefficients; write only while no item is in flight.
// Throughput: one item per cycle, sustained while the receiver keeps m_tready high.
// The front end is a restoring divider with one quotient bit per stage; the
// back end is a 10-stage multiply pipeline ending in the output register.
// A 4-entry queue separates the two halves: a stalled receiver freezes the
// back end, the queue fills, and only then does s_tready drop.
// Reset (aresetn low, synchronous) empties all pipelines and the queue and
// loads the default focal lengths (2561) and zero coefficients.
module lens_distortion_coordinate_map #(
    parameter int IMG_WIDTH       = ldcm_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT      = ldcm_pkg::IMG_HEIGHT_DEF,
    parameter int CENTER_X        = ldcm_pkg::CENTER_X_DEF,
    parameter int CENTER_Y        = ldcm_pkg::CENTER_Y_DEF,
    parameter int COEF_FRAC_BITS  = ldcm_pkg::COEF_FRAC_BITS_DEF,
    parameter int COORD_FRAC_BITS = ldcm_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // dest_row[9:0], dest_col[20:10], zero pad
    input  logic [ldcm_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // src_row[9:0], src_col[20:10], zero pad
    output logic [ldcm_pkg::OUT_DATA_W-1:0]   m_tdata,
    // inside_res[0]
    output logic                              m_tuser,
    input  logic                              cfg_we,
    input  logic [ldcm_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [ldcm_pkg::COEF_W-1:0]       cfg_wdata
);
    import ldcm_pkg::*;

    ldcm_cfg_t        cfg_reg;
    ldcm_qctl_t       qctl;
    ldcm_norm_t       f_item, b_item;
    logic             q_full, q_empty, q_pop;
    logic [ROW_W-1:0] src_row;
    logic [COL_W-1:0] src_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.focal_x <= FOCAL_W'(2561);
            cfg_reg.focal_y <= FOCAL_W'(2561);
            cfg_reg.k1      <= '0;
            cfg_reg.k2      <= '0;
            cfg_reg.k3      <= '0;
            cfg_reg.p1      <= '0;
            cfg_reg.p2      <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_FOCAL_X: cfg_reg.focal_x <= cfg_wdata[FOCAL_W-1:0];
                REG_FOCAL_Y: cfg_reg.focal_y <= cfg_wdata[FOCAL_W-1:0];
                REG_K1:      cfg_reg.k1      <= cfg_wdata;
                REG_K2:      cfg_reg.k2      <= cfg_wdata;
                REG_K3:      cfg_reg.k3      <= cfg_wdata;
                REG_P1:      cfg_reg.p1      <= cfg_wdata;
                REG_P2:      cfg_reg.p2      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    ldcm_front #(
        .CENTER_X(CENTER_X), .CENTER_Y(CENTER_Y), .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .dest_row(s_tdata[ROW_W-1:0]), .dest_col(s_tdata[ROW_W+COL_W-1:ROW_W]),
        .focal_x(cfg_reg.focal_x), .focal_y(cfg_reg.focal_y),
        .qctl_out(qctl), .q_full(q_full), .q_item(f_item)
    );

    ldcm_fifo #(.DEPTH(QUEUE_DEPTH_DEF)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .qctl_in(qctl), .wr_item(f_item), .full(q_full),
        .pop(q_pop), .empty(q_empty), .rd_item(b_item)
    );

    ldcm_back #(
        .IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT),
        .CENTER_X(CENTER_X), .CENTER_Y(CENTER_Y),
        .COEF_FRAC_BITS(COEF_FRAC_BITS), .COORD_FRAC_BITS(COORD_FRAC_BITS)
    ) u_back (
        .aclk(aclk), .aresetn(aresetn), .cfg(cfg_reg),
        .q_empty(q_empty), .q_item(b_item), .q_pop(q_pop),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .src_row(src_row), .src_col(src_col), .inside_res(m_tuser)
    );

    assign m_tdata = {(OUT_DATA_W-ROW_W-COL_W)'(0), src_col, src_row};

endmodule

// ===== sv/ldcm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the lens distortion coordinate map, bound to the top level.
module ldcm_checker #(
    parameter int IMG_WIDTH  = ldcm_pkg::IMG_WIDTH_DEF,
    parameter int IMG_HEIGHT = ldcm_pkg::IMG_HEIGHT_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [ldcm_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tuser
);
    import ldcm_pkg::*;

    // nothing comes out in the cycle after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled output item changed");

    // black pixels carry a zero coordinate
    a_black_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("outside item with nonzero coordinate");

    a_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |->
            (13'(m_tdata[ROW_W-1:0]) < 13'(IMG_HEIGHT)) &&
            (13'(m_tdata[ROW_W+COL_W-1:ROW_W]) < 13'(IMG_WIDTH)))
        else $error("inside item beyond image");

endmodule

bind lens_distortion_coordinate_map ldcm_checker #(
    .IMG_WIDTH(IMG_WIDTH), .IMG_HEIGHT(IMG_HEIGHT)
) u_ldcm_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);
